### rtl/core/sprc_pkg.sv
// ----------------------------------------------------------------------------
// sprc_pkg
// Shared types and constants for the streaming pattern replace block.
// ----------------------------------------------------------------------------
`default_nettype none

package sprc_pkg;

  // Default sizes handed to the top level parameters
  localparam int MAX_PATTERN_DEF     = 8;
  localparam int MAX_REPLACEMENT_DEF = 8;
  localparam int COUNT_WIDTH_DEF     = 32;

  // Fixed field widths
  localparam int BYTE_W      = 8;
  localparam int LEN_W       = 4;
  localparam int BYTES_W     = 64;
  localparam int MATCH_CNT_W = 32;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 64;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PATTERN_LENGTH     = 2'd0,
    CFG_PATTERN_BYTES      = 2'd1,
    CFG_REPLACEMENT_LENGTH = 2'd2,
    CFG_REPLACEMENT_BYTES  = 2'd3
  } cfg_reg_t;

  // What every cell of the window chain does in a cycle
  typedef enum logic [1:0] {
    CELL_HOLD  = 2'd0,  // keep the byte
    CELL_WRITE = 2'd1,  // take the incoming byte if this is the free slot
    CELL_SHIFT = 2'd2,  // take the neighbor's byte (move toward the head)
    CELL_LOAD  = 2'd3   // take a replacement byte
  } cell_mode_t;

  typedef struct packed {
    cell_mode_t mode;
    logic       insert;  // incoming byte shows in the free slot this cycle
  } cell_ctl_t;

  // Controller states
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EMIT = 1'b1
  } state_t;

endpackage

`default_nettype wire

### rtl/core/sprc_cell.sv
// ----------------------------------------------------------------------------
// sprc_cell
// One window position: holds a byte, compares it against its pattern byte
// and passes it on to the neighbor toward the head of the chain.
// ----------------------------------------------------------------------------
`default_nettype none

module sprc_cell (
  input  wire logic                       clk,
  input  wire sprc_pkg::cell_ctl_t        ctl,
  input  wire logic                       slot,       // this cell is the free slot
  input  wire logic [sprc_pkg::BYTE_W-1:0] in_byte,
  input  wire logic [sprc_pkg::BYTE_W-1:0] nbr_byte,  // effective byte of next cell
  input  wire logic [sprc_pkg::BYTE_W-1:0] repl_byte,
  input  wire logic [sprc_pkg::BYTE_W-1:0] pat_byte,
  output logic      [sprc_pkg::BYTE_W-1:0] eff_byte,
  output logic                            match
);

  logic [sprc_pkg::BYTE_W-1:0] data_r;
  logic [sprc_pkg::BYTE_W-1:0] data_nxt;

  // Effective byte: the incoming byte lands in the free slot this cycle
  assign eff_byte = (ctl.insert && slot) ? in_byte : data_r;
  assign match    = (eff_byte == pat_byte);

  // Select next content
  always_comb begin
    unique case (ctl.mode)
      sprc_pkg::CELL_HOLD:  data_nxt = data_r;
      sprc_pkg::CELL_WRITE: data_nxt = eff_byte;
      sprc_pkg::CELL_SHIFT: data_nxt = nbr_byte;
      sprc_pkg::CELL_LOAD:  data_nxt = repl_byte;
      default:              data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule

`default_nettype wire

### rtl/core/sprc_chain.sv
// ----------------------------------------------------------------------------
// sprc_chain
// Row of window cells. Reports the byte at the head and whether the window,
// with the incoming byte in place, equals the pattern.
// ----------------------------------------------------------------------------
`default_nettype none

module sprc_chain #(
  parameter int MAX_PATTERN     = sprc_pkg::MAX_PATTERN_DEF,
  parameter int MAX_REPLACEMENT = sprc_pkg::MAX_REPLACEMENT_DEF,
  parameter int CELLS           = sprc_pkg::MAX_PATTERN_DEF,
  parameter int FW              = $clog2(sprc_pkg::MAX_PATTERN_DEF + 1)
) (
  input  wire logic                          clk,
  input  wire sprc_pkg::cell_ctl_t           ctl,
  input  wire logic [FW-1:0]                 fill,
  input  wire logic [sprc_pkg::LEN_W-1:0]    plen,
  input  wire logic [sprc_pkg::BYTE_W-1:0]   in_byte,
  input  wire logic [sprc_pkg::BYTES_W-1:0]  pattern_bytes,
  input  wire logic [sprc_pkg::BYTES_W-1:0]  replacement_bytes,
  output logic      [sprc_pkg::BYTE_W-1:0]   head_byte,
  output logic                               hit
);

  logic [sprc_pkg::BYTE_W-1:0] eff   [CELLS+1];
  logic [CELLS-1:0]            match;
  logic [CELLS-1:0]            mask;

  // Nothing enters behind the tail
  assign eff[CELLS] = '0;

  for (genvar i = 0; i < CELLS; i++) begin : g_cell
    logic                        slot;
    logic [sprc_pkg::BYTE_W-1:0] pat_b;
    logic [sprc_pkg::BYTE_W-1:0] repl_b;

    // Pattern positions exist only below MAX_PATTERN
    if (i < MAX_PATTERN) begin : g_pat
      assign slot    = (fill == FW'(i));
      assign pat_b   = pattern_bytes[sprc_pkg::BYTE_W*i +: sprc_pkg::BYTE_W];
      assign mask[i] = (sprc_pkg::LEN_W'(i) < plen);
    end else begin : g_nopat
      assign slot    = 1'b0;
      assign pat_b   = '0;
      assign mask[i] = 1'b0;
    end

    // Cell i holds replacement byte i+1 after a match (byte 0 goes out at once)
    if (i + 1 < MAX_REPLACEMENT) begin : g_repl
      assign repl_b = replacement_bytes[sprc_pkg::BYTE_W*(i+1) +: sprc_pkg::BYTE_W];
    end else begin : g_norepl
      assign repl_b = '0;
    end

    sprc_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .slot      (slot),
      .in_byte   (in_byte),
      .nbr_byte  (eff[i+1]),
      .repl_byte (repl_b),
      .pat_byte  (pat_b),
      .eff_byte  (eff[i]),
      .match     (match[i])
    );
  end

  assign head_byte = eff[0];
  assign hit       = &(match | ~mask);

endmodule

`default_nettype wire

### rtl/core/stream_pattern_replace_count_top.sv
// ----------------------------------------------------------------------------
// stream_pattern_replace_count_top
// Streaming substring replace with a saturating match count.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake          payload
//   in_      in         in_valid/in_stall  in_byte, in_end_of_input
//   out_     out        out_valid/out_stall out_byte, out_byte_valid,
//                                          out_final_result, out_match_count
//   cfg_     in         cfg_valid/cfg_ready cfg_index, cfg_data
//
// A byte that yields more than one result (replacement or final flush) holds
// the input off while the window chain shifts the rest to the output register,
// one byte per cycle when the output does not stall.
// Reset is synchronous and clears control state, counters and config.
// A stall on the output holds the output register and stalls the input.
// ----------------------------------------------------------------------------
`default_nettype none

module stream_pattern_replace_count_top #(
  parameter int MAX_PATTERN     = sprc_pkg::MAX_PATTERN_DEF,
  parameter int MAX_REPLACEMENT = sprc_pkg::MAX_REPLACEMENT_DEF,
  parameter int COUNT_WIDTH     = sprc_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // input channel
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [sprc_pkg::BYTE_W-1:0]       in_byte,
  input  wire logic                              in_end_of_input,
  // result channel
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic      [sprc_pkg::BYTE_W-1:0]       out_byte,
  output logic                                   out_byte_valid,
  output logic                                   out_final_result,
  output logic      [sprc_pkg::MATCH_CNT_W-1:0]  out_match_count,
  // configuration
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [sprc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [sprc_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int CELLS = (MAX_PATTERN > MAX_REPLACEMENT) ? MAX_PATTERN : MAX_REPLACEMENT;
  localparam int FW    = $clog2(MAX_PATTERN + 1);
  localparam int RW    = $clog2(CELLS + 1);
  localparam int LW    = sprc_pkg::LEN_W;
  localparam int BW    = sprc_pkg::BYTE_W;
  localparam int MW    = sprc_pkg::MATCH_CNT_W;

  // configuration registers
  logic [LW-1:0]                pat_len_r;
  logic [sprc_pkg::BYTES_W-1:0] pat_bytes_r;
  logic [LW-1:0]                repl_len_r;
  logic [sprc_pkg::BYTES_W-1:0] repl_bytes_r;

  // control and counters
  sprc_pkg::state_t   state_r, state_nxt;
  logic [FW-1:0]      fill_r, fill_nxt;
  logic [RW-1:0]      rem_r, rem_nxt;
  logic               last_r, last_nxt;
  logic [MW-1:0]      fcnt_r, fcnt_nxt;
  logic [COUNT_WIDTH-1:0] matches_r, matches_nxt;
  logic [COUNT_WIDTH-1:0] bytes_r, bytes_nxt;

  // output register
  logic           out_valid_r;
  logic [BW-1:0]  obyte_r, obyte_nxt;
  logic           obv_r, obv_nxt;
  logic           ofin_r, ofin_nxt;
  logic [MW-1:0]  ocnt_r, ocnt_nxt;
  logic           out_load;

  // datapath
  sprc_pkg::cell_ctl_t    cell_ctl;
  logic [LW-1:0]          plen_eff;
  logic [LW-1:0]          rlen_eff;
  logic                   plen_zero;
  logic                   full;
  logic                   chain_hit;
  logic                   hit;
  logic [BW-1:0]          head_byte;
  logic                   out_free;
  logic                   in_acc;
  logic [COUNT_WIDTH-1:0] bytes_inc;
  logic [COUNT_WIDTH-1:0] bytes_inc2;
  logic [COUNT_WIDTH-1:0] match_inc;
  logic [COUNT_WIDTH-1:0] cnt_sel;
  logic [MW-1:0]          cnt32;
  logic                   fin;

  // Clamp lengths to what the hardware holds
  assign plen_eff  = (pat_len_r > LW'(MAX_PATTERN)) ? LW'(MAX_PATTERN) : pat_len_r;
  assign rlen_eff  = (repl_len_r > LW'(MAX_REPLACEMENT)) ? LW'(MAX_REPLACEMENT) : repl_len_r;
  assign plen_zero = (plen_eff == '0);
  assign full      = ((LW'(fill_r) + LW'(1)) == plen_eff);
  assign hit       = full && chain_hit;

  // Handshakes
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = !((state_r == sprc_pkg::ST_IDLE) && out_free);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // Saturating counters and the reported count
  assign bytes_inc  = (&bytes_r)   ? bytes_r   : bytes_r + COUNT_WIDTH'(1);
  assign bytes_inc2 = (&bytes_inc) ? bytes_inc : bytes_inc + COUNT_WIDTH'(1);
  assign match_inc  = (&matches_r) ? matches_r : matches_r + COUNT_WIDTH'(1);
  assign cnt_sel    = plen_zero ? bytes_inc2 : (hit ? match_inc : matches_r);

  if (COUNT_WIDTH > MW) begin : g_clamp
    assign cnt32 = (|cnt_sel[COUNT_WIDTH-1:MW]) ? '1 : cnt_sel[MW-1:0];
  end else begin : g_noclamp
    assign cnt32 = MW'(cnt_sel);
  end

  sprc_chain #(
    .MAX_PATTERN     (MAX_PATTERN),
    .MAX_REPLACEMENT (MAX_REPLACEMENT),
    .CELLS           (CELLS),
    .FW              (FW)
  ) u_chain (
    .clk               (clk),
    .ctl               (cell_ctl),
    .fill              (fill_r),
    .plen              (plen_eff),
    .in_byte           (in_byte),
    .pattern_bytes     (pat_bytes_r),
    .replacement_bytes (repl_bytes_r),
    .head_byte         (head_byte),
    .hit               (chain_hit)
  );

  // Next state, chain control and output load
  always_comb begin
    state_nxt       = state_r;
    fill_nxt        = fill_r;
    rem_nxt         = rem_r;
    last_nxt        = last_r;
    fcnt_nxt        = fcnt_r;
    matches_nxt     = matches_r;
    bytes_nxt       = bytes_r;
    cell_ctl.mode   = sprc_pkg::CELL_HOLD;
    cell_ctl.insert = 1'b0;
    out_load        = 1'b0;
    obyte_nxt       = '0;
    obv_nxt         = 1'b1;
    ofin_nxt        = 1'b0;
    ocnt_nxt        = '0;
    fin             = 1'b0;

    unique case (state_r)
      sprc_pkg::ST_IDLE: begin
        if (in_acc) begin
          bytes_nxt       = bytes_inc;
          cell_ctl.insert = !plen_zero;
          priority if (plen_zero) begin
            // pass through
            out_load  = 1'b1;
            obyte_nxt = in_byte;
            ofin_nxt  = in_end_of_input;
            ocnt_nxt  = in_end_of_input ? cnt32 : '0;
          end else if (hit) begin
            // replace: byte 0 goes out now, the rest wait in the chain
            cell_ctl.mode = sprc_pkg::CELL_LOAD;
            fill_nxt      = '0;
            matches_nxt   = match_inc;
            if (rlen_eff != '0) begin
              fin       = in_end_of_input && (rlen_eff == LW'(1));
              out_load  = 1'b1;
              obyte_nxt = repl_bytes_r[BW-1:0];
              ofin_nxt  = fin;
              ocnt_nxt  = fin ? cnt32 : '0;
              if (rlen_eff != LW'(1)) begin
                rem_nxt   = RW'(rlen_eff - LW'(1));
                last_nxt  = in_end_of_input;
                fcnt_nxt  = cnt32;
                state_nxt = sprc_pkg::ST_EMIT;
              end
            end else if (in_end_of_input) begin
              // empty final marker
              out_load = 1'b1;
              obv_nxt  = 1'b0;
              ofin_nxt = 1'b1;
              ocnt_nxt = cnt32;
            end
          end else if (full || in_end_of_input) begin
            // drop the oldest byte out of the window; flush the rest on last
            cell_ctl.mode = sprc_pkg::CELL_SHIFT;
            out_load      = 1'b1;
            obyte_nxt     = head_byte;
            if (in_end_of_input) begin
              fin      = (fill_r == '0);
              ofin_nxt = fin;
              ocnt_nxt = fin ? cnt32 : '0;
              fill_nxt = '0;
              if (!fin) begin
                rem_nxt   = RW'(fill_r);
                last_nxt  = 1'b1;
                fcnt_nxt  = cnt32;
                state_nxt = sprc_pkg::ST_EMIT;
              end
            end
          end else begin
            // window still filling
            cell_ctl.mode = sprc_pkg::CELL_WRITE;
            fill_nxt      = fill_r + FW'(1);
          end
          if (in_end_of_input) begin
            bytes_nxt   = '0;
            matches_nxt = '0;
          end
        end
      end
      sprc_pkg::ST_EMIT: begin
        if (out_free) begin
          // advance the chain one byte into the output register
          cell_ctl.mode = sprc_pkg::CELL_SHIFT;
          fin           = last_r && (rem_r == RW'(1));
          out_load      = 1'b1;
          obyte_nxt     = head_byte;
          ofin_nxt      = fin;
          ocnt_nxt      = fin ? fcnt_r : '0;
          rem_nxt       = rem_r - RW'(1);
          if (rem_r == RW'(1)) begin
            state_nxt = sprc_pkg::ST_IDLE;
          end
        end
      end
      default: state_nxt = sprc_pkg::ST_IDLE;
    endcase

    // A new pattern length drops the held window
    if (cfg_valid && cfg_ready &&
        (sprc_pkg::cfg_reg_t'(cfg_index) == sprc_pkg::CFG_PATTERN_LENGTH)) begin
      fill_nxt = '0;
    end
  end

  // Control registers, counters and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= sprc_pkg::ST_IDLE;
      fill_r       <= '0;
      rem_r        <= '0;
      last_r       <= 1'b0;
      matches_r    <= '0;
      bytes_r      <= '0;
      out_valid_r  <= 1'b0;
      pat_len_r    <= '0;
      pat_bytes_r  <= '0;
      repl_len_r   <= '0;
      repl_bytes_r <= '0;
    end else begin
      state_r   <= state_nxt;
      fill_r    <= fill_nxt;
      rem_r     <= rem_nxt;
      last_r    <= last_nxt;
      matches_r <= matches_nxt;
      bytes_r   <= bytes_nxt;

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end

      // configuration transfer
      if (cfg_valid && cfg_ready) begin
        unique case (sprc_pkg::cfg_reg_t'(cfg_index))
          sprc_pkg::CFG_PATTERN_LENGTH:     pat_len_r    <= cfg_data[LW-1:0];
          sprc_pkg::CFG_PATTERN_BYTES:      pat_bytes_r  <= cfg_data;
          sprc_pkg::CFG_REPLACEMENT_LENGTH: repl_len_r   <= cfg_data[LW-1:0];
          sprc_pkg::CFG_REPLACEMENT_BYTES:  repl_bytes_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    fcnt_r <= fcnt_nxt;
    if (out_load) begin
      obyte_r <= obyte_nxt;
      obv_r   <= obv_nxt;
      ofin_r  <= ofin_nxt;
      ocnt_r  <= ocnt_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_byte         = obyte_r;
  assign out_byte_valid   = obv_r;
  assign out_final_result = ofin_r;
  assign out_match_count  = ocnt_r;

  // Checks
  a_emit_has_work: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sprc_pkg::ST_EMIT) |-> (rem_r != '0))
    else $error("emit state with nothing left to send");

  a_fill_below_len: assert property (@(posedge clk) disable iff (!rst_n)
    (!plen_zero) |-> (LW'(fill_r) < plen_eff))
    else $error("window fill reached pattern length");

  a_marker_is_final: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !obv_r) |-> ofin_r)
    else $error("empty result that is not the final one");

  a_emit_stalls_input: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sprc_pkg::ST_EMIT) |=> (!in_acc || $past(rem_r) == RW'(1)))
    else $error("input taken while a flush or replacement is in flight");

endmodule

`default_nettype wire

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for stream_pattern_replace_count_top. Byte streams are
// pushed under a range of pattern and replacement settings. A scoreboard
// predicts every output byte, the flush and the final match count, and
// compares the result channel in order while both sides idle at random.
// ----------------------------------------------------------------------------

// One expected or observed result transfer
typedef struct packed {
  logic [7:0]  data;
  logic        data_valid;
  logic        last;
  logic [31:0] count;
} replace_out_t;

class replace_scoreboard;
  logic [3:0]   pat_len;
  logic [63:0]  pat_bytes;
  logic [3:0]   rep_len;
  logic [63:0]  rep_bytes;
  logic [7:0]   window [8];
  int unsigned  fill;
  logic [31:0]  hits;
  logic [31:0]  seen;
  replace_out_t expected_q [$];
  int unsigned  errors;

  function new();
    pat_len   = '0;
    pat_bytes = '0;
    rep_len   = '0;
    rep_bytes = '0;
    foreach (window[i]) window[i] = '0;
    fill      = 0;
    hits      = '0;
    seen      = '0;
    errors    = 0;
  endfunction

  function void report(string msg);
    $display("ERROR @%0t: %s", $time, msg);
    errors++;
  endfunction

  function int unsigned pending_count();
    return expected_q.size();
  endfunction

  function logic [31:0] sat_inc(logic [31:0] v);
    return (v == '1) ? v : v + 32'd1;
  endfunction

  function void push_byte(logic [7:0] b, logic bv);
    replace_out_t r;
    r = '{data: b, data_valid: bv, last: 1'b0, count: 32'd0};
    expected_q.insert(expected_q.size(), r);
  endfunction

  // Track a register write; a new pattern length drops the window
  function void write_reg(logic [1:0] idx, logic [63:0] val);
    case (idx)
      sprc_pkg::CFG_PATTERN_LENGTH: begin
        pat_len = val[3:0];
        fill    = 0;
      end
      sprc_pkg::CFG_PATTERN_BYTES:      pat_bytes = val;
      sprc_pkg::CFG_REPLACEMENT_LENGTH: rep_len   = val[3:0];
      sprc_pkg::CFG_REPLACEMENT_BYTES:  rep_bytes = val;
      default: ;
    endcase
  endfunction

  // Predict the results of one accepted input byte
  function void note_input(logic [7:0] b, logic eoi);
    int unsigned  plen;
    int unsigned  rlen;
    int unsigned  n;
    bit           hit;
    logic [31:0]  cnt;
    replace_out_t tail;
    plen = (pat_len > 4'd8) ? 8 : pat_len;
    rlen = (rep_len > 4'd8) ? 8 : rep_len;
    n    = 0;
    seen = sat_inc(seen);
    if (plen == 0) begin
      push_byte(b, 1'b1);
      n++;
    end else begin
      if (fill < plen) begin
        window[fill] = b;
        fill++;
      end
      if (fill >= plen) begin
        hit = 1'b1;
        for (int i = 0; i < plen; i++)
          if (window[i] != pat_bytes[8*i +: 8]) hit = 1'b0;
        if (hit) begin
          // emit the replacement and clear the window
          for (int i = 0; i < rlen; i++) begin
            push_byte(rep_bytes[8*i +: 8], 1'b1);
            n++;
          end
          fill = 0;
          hits = sat_inc(hits);
        end else begin
          // emit the oldest byte and advance the window
          push_byte(window[0], 1'b1);
          n++;
          for (int i = 1; i < 8; i++) window[i-1] = window[i];
          fill--;
        end
      end
    end
    if (eoi) begin
      // flush leftovers, tag the last transfer with the count
      for (int i = 0; i < fill; i++) begin
        push_byte(window[i], 1'b1);
        n++;
      end
      if (n == 0) push_byte(8'h00, 1'b0);
      cnt        = (plen == 0) ? sat_inc(seen) : hits;
      tail       = expected_q[expected_q.size() - 1];
      tail.last  = 1'b1;
      tail.count = cnt;
      expected_q[expected_q.size() - 1] = tail;
      fill = 0;
      hits = '0;
      seen = '0;
    end
  endfunction

  // Compare one result transfer with the oldest expectation
  function void check_result(replace_out_t got);
    replace_out_t want;
    if (expected_q.size() == 0) begin
      report($sformatf("unexpected result: byte %h valid %b final %b count %0d",
                       got.data, got.data_valid, got.last, got.count));
      return;
    end
    want = expected_q.pop_front();
    if (got.data !== want.data)
      report($sformatf("out_byte %h, expected %h", got.data, want.data));
    if (got.data_valid !== want.data_valid)
      report($sformatf("out_byte_valid %b, expected %b", got.data_valid, want.data_valid));
    if (got.last !== want.last)
      report($sformatf("out_final_result %b, expected %b", got.last, want.last));
    if (got.count !== want.count)
      report($sformatf("out_match_count %0d, expected %0d", got.count, want.count));
  endfunction
endclass

module tb;

  localparam int DRAIN_CYCLES = 16;
  localparam int QUIET_LIMIT  = 2000;
  localparam int RANDOM_ITEMS = 500;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_PATTERN,
    STALL_HEAVY
  } stall_mode_t;

  logic        clk             = 1'b0;
  logic        rst_n           = 1'b0;
  logic        in_valid        = 1'b0;
  logic        in_stall;
  logic [7:0]  in_byte         = 8'h00;
  logic        in_end_of_input = 1'b0;
  logic        out_valid;
  logic        out_stall       = 1'b0;
  logic [7:0]  out_byte;
  logic        out_byte_valid;
  logic        out_final_result;
  logic [31:0] out_match_count;
  logic        cfg_valid       = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index       = 2'b00;
  logic [63:0] cfg_data        = 64'd0;

  replace_scoreboard sb;
  int unsigned       items_sent   = 0;
  int unsigned       burst_left   = 0;
  int unsigned       quiet_cycles = 0;
  stall_mode_t       stall_mode   = STALL_NONE;
  int unsigned       stall_left   = 0;
  logic [7:0]        stall_mask   = 8'h00;

  stream_pattern_replace_count_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_byte          (in_byte),
    .in_end_of_input  (in_end_of_input),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_byte         (out_byte),
    .out_byte_valid   (out_byte_valid),
    .out_final_result (out_final_result),
    .out_match_count  (out_match_count),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Receiver stall: switch between stall modes after a random hold
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= stall_mode_t'($urandom_range(0, 3));
      stall_left <= $urandom_range(40, 300);
      stall_mask <= 8'($urandom);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      STALL_NONE:    out_stall <= 1'b0;
      STALL_LIGHT:   out_stall <= ($urandom_range(0, 99) < 30);
      STALL_PATTERN: out_stall <= stall_mask[stall_left % 8];
      default:       out_stall <= ($urandom_range(0, 99) < 75);
    endcase
  end

  // Observe every transfer, feed the scoreboard, watch for a hang
  always @(posedge clk) begin : monitor
    replace_out_t got;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (in_valid && !in_stall) sb.note_input(in_byte, in_end_of_input);
      if (out_valid && !out_stall) begin
        got = '{data: out_byte, data_valid: out_byte_valid,
                last: out_final_result, count: out_match_count};
        sb.check_result(got);
      end
      if ((cfg_valid && cfg_ready) || (in_valid && !in_stall) || (out_valid && !out_stall))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("FAIL stream_pattern_replace_count_top");
        $finish;
      end
    end
  end

  // Sender pacing: bursts of random length, random gaps in between
  task automatic pace_sender();
    int unsigned gap;
    if (burst_left != 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 20);
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Offer one byte and hold it until the transfer
  task automatic send_item(logic [7:0] b, logic eoi);
    in_valid        <= 1'b1;
    in_byte         <= b;
    in_end_of_input <= eoi;
    do @(posedge clk); while (!(in_valid && !in_stall));
    items_sent++;
    pace_sender();
  endtask

  // Drop valid, drain all expected results, then let trailing work settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_count() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(sprc_pkg::cfg_reg_t idx, logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
  endtask

  task automatic configure(logic [63:0] plen_w, logic [63:0] pbytes,
                           logic [63:0] rlen_w, logic [63:0] rbytes);
    cfg_write(sprc_pkg::CFG_PATTERN_BYTES, pbytes);
    cfg_write(sprc_pkg::CFG_REPLACEMENT_BYTES, rbytes);
    cfg_write(sprc_pkg::CFG_REPLACEMENT_LENGTH, rlen_w);
    cfg_write(sprc_pkg::CFG_PATTERN_LENGTH, plen_w);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_directed();
    // pass-through after reset, count is length plus one
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b1);
    wait_idle();
    // match followed by a two-byte flush
    configure(64'd3, 64'hA5A5_A5A5_A563_6261, 64'd2, 64'h0000_0000_0000_5958);
    send_item(8'h61, 1'b0);
    send_item(8'h62, 1'b0);
    send_item(8'h63, 1'b0);
    send_item(8'h61, 1'b0);
    send_item(8'h62, 1'b1);
    wait_idle();
    // empty replacement on the final byte leaves only the empty marker
    configure(64'd3, 64'h0000_0000_0063_6261, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(8'h61, 1'b0);
    send_item(8'h62, 1'b0);
    send_item(8'h63, 1'b1);
    wait_idle();
    // oversized lengths clamp to eight, full replacement on the final byte
    configure(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
              64'hFFFF_FFFF_FFFF_FFFF, 64'h0123_4567_89AB_CDEF);
    for (int i = 0; i < 8; i++) send_item(8'hFF, i == 7);
    wait_idle();
    // rewrite the length mid-stream: the held byte is dropped
    configure(64'd2, 64'h0000_0000_0000_6261, 64'd1, 64'h0000_0000_0000_005A);
    send_item(8'h61, 1'b0);
    wait_idle();
    configure(64'd2, 64'h0000_0000_0000_6261, 64'd1, 64'h0000_0000_0000_005A);
    send_item(8'h62, 1'b1);
  endtask

  task automatic run_random();
    logic [7:0]  sym [4];
    logic [7:0]  stream_q [$];
    logic [63:0] plen_w;
    logic [63:0] pbytes;
    logic [63:0] rlen_w;
    logic [63:0] rbytes;
    int unsigned plen;
    int unsigned len;
    int unsigned pick;
    int unsigned cut;
    int unsigned start_count;
    bit          leave_open;
    start_count = items_sent;
    plen        = 0;
    pbytes      = '0;
    leave_open  = 1'b0;
    foreach (sym[i]) sym[i] = '0;
    while (items_sent - start_count < RANDOM_ITEMS) begin
      // new setting for most streams; a small alphabet keeps matches common
      if (items_sent == start_count || $urandom_range(0, 9) < 6) begin
        foreach (sym[i])
          sym[i] = ($urandom_range(0, 3) == 0) ? ($urandom_range(0, 1) ? 8'hFF : 8'h00)
                                               : 8'($urandom);
        plen_w = ($urandom_range(0, 4) == 0) ? {$urandom, $urandom} : 64'd0;
        case ($urandom_range(0, 9))
          0:       plen_w[3:0] = 4'd0;
          1:       plen_w[3:0] = 4'($urandom_range(9, 15));
          2, 3:    plen_w[3:0] = 4'd8;
          default: plen_w[3:0] = 4'($urandom_range(1, 4));
        endcase
        plen   = (plen_w[3:0] > 4'd8) ? 8 : plen_w[3:0];
        pbytes = {$urandom, $urandom};
        for (int i = 0; i < plen; i++) pbytes[8*i +: 8] = sym[$urandom_range(0, 3)];
        rlen_w = ($urandom_range(0, 4) == 0) ? {$urandom, $urandom} : 64'd0;
        rlen_w[3:0] = ($urandom_range(0, 6) == 0) ? 4'($urandom_range(9, 15))
                                                  : 4'($urandom_range(0, 8));
        rbytes = {$urandom, $urandom};
        wait_idle();
        configure(plen_w, pbytes, rlen_w, rbytes);
      end
      // build a stream mostly from whole and partial copies of the pattern
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(21, 60) : $urandom_range(1, 20);
      stream_q.delete();
      while (stream_q.size() < len) begin
        pick = $urandom_range(0, 99);
        if (plen != 0 && pick < 40) begin
          for (int i = 0; i < plen; i++) stream_q.insert(stream_q.size(), pbytes[8*i +: 8]);
        end else if (plen > 1 && pick < 55) begin
          cut = $urandom_range(1, plen - 1);
          for (int i = 0; i < cut; i++) stream_q.insert(stream_q.size(), pbytes[8*i +: 8]);
        end else if (pick < 90) begin
          stream_q.insert(stream_q.size(), sym[$urandom_range(0, 3)]);
        end else begin
          stream_q.insert(stream_q.size(), 8'($urandom));
        end
      end
      leave_open = ($urandom_range(0, 9) == 0);
      foreach (stream_q[i])
        send_item(stream_q[i], !leave_open && (i == stream_q.size() - 1));
    end
    // close a stream left open at the end
    if (leave_open) send_item(8'($urandom), 1'b1);
  endtask

  initial begin
    sb = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    run_random();
    wait_idle();
    if (sb.errors == 0)
      $display("PASS stream_pattern_replace_count_top");
    else
      $display("FAIL stream_pattern_replace_count_top");
    $finish;
  end

endmodule
